// ----- rtl/stack_machine_executor_top_defines.svh -----
// Assertion macros used by the executor sequencer.
`ifndef STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define SMX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define SMX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMX_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/smx_pkg.sv -----
package smx_pkg;

  typedef enum logic [4:0] {
    OP_RET       = 5'd0,
    OP_POP       = 5'd1,
    OP_PUSH      = 5'd2,
    OP_ADD       = 5'd3,
    OP_SUB       = 5'd4,
    OP_MUL       = 5'd5,
    OP_DIV       = 5'd6,
    OP_PRINT     = 5'd7,
    OP_EQ        = 5'd8,
    OP_NEQ       = 5'd9,
    OP_LT        = 5'd10,
    OP_LTEQ      = 5'd11,
    OP_GT        = 5'd12,
    OP_GTEQ      = 5'd13,
    OP_IF_JUMP   = 5'd14,
    OP_CALL      = 5'd15,
    OP_ARG_FETCH = 5'd16
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_HALT  = 3'd1,
    ST_DIV0  = 3'd2,
    ST_OVER  = 3'd3,
    ST_UNDER = 3'd4
  } status_t;

  // Stack read address selects
  typedef enum logic [2:0] {
    RD_TOP,
    RD_TOPM1,
    RD_FPM1,
    RD_FPM2,
    RD_FP,
    RD_ARG
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_W1,
    S_W2,
    S_EXEC,
    S_DIV,
    S_DWB
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    clr_wr;
    rd_sel_t rd_sel;
    logic    cap_en;
    logic [1:0] cap_idx;
    logic    wr_call1;
    logic    wr_call2;
    logic    div_start;
    logic    commit;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t op;
    status_t st;
    logic    call_ok;
    logic    clr_done;
    logic    div_done;
    logic    out_free;
  } dp_sts_t;

endpackage

// ----- rtl/smx_ram.sv -----
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/smx_div.sv -----
module smx_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        neg_r;
  logic [32:0] shifted, diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_r <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule

// ----- rtl/smx_dp.sv -----
module smx_dp #(
  parameter int STACK_DEPTH    = 1024,
  parameter int CODE_ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  smx_pkg::ctl_cmd_t   cmd,
  output smx_pkg::dp_sts_t    sts,
  input  logic [4:0]          in_opcode,
  input  logic signed [31:0]  in_immediate,
  input  logic [15:0]         in_call_target,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_next_pc,
  output logic [2:0]          out_status,
  output logic                out_print_valid,
  output logic signed [31:0]  out_print_value,
  output logic [9:0]          out_print_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = CODE_ADDR_BITS;
  localparam int EW = AW + 2;
  localparam int XW = 34;

  smx_pkg::opcode_t op_r;
  logic [31:0]      imm_r;
  logic [15:0]      tgt_r;
  logic [AW-1:0]    top_r, fp_r, clr_cnt_r;
  logic [CW-1:0]    pc_r;
  logic [31:0]      opnd_r [4];

  logic             out_valid_r, out_print_valid_r;
  logic [15:0]      out_next_pc_r;
  logic [2:0]       out_status_r;
  logic [31:0]      out_print_value_r;
  logic [9:0]       out_print_depth_r;

  logic [AW-1:0]    top_nxt, fp_nxt;
  logic [CW-1:0]    pc_nxt;
  smx_pkg::status_t st;

  logic [EW-1:0]    top_x;
  logic             top_zero, push_ovf, call_ovf, ld_bad, nt_bad, nf_bad;
  logic [XW-1:0]    fp_x, ld_idx, nt;
  logic [31:0]      nf, a, b, alu, quo;
  logic [31:0]      mul_lo;
  logic [CW-1:0]    pc_p1, pc_p2, pc_p3, ra_p1;

  logic             ram_we, ex_we, div_done;
  logic [AW-1:0]    ram_waddr, ram_raddr, ex_addr;
  logic [31:0]      ram_wdata, ram_rdata, ex_data;

  assign b = opnd_r[0];
  assign a = opnd_r[1];

  assign top_x    = EW'(top_r);
  assign top_zero = (top_r == '0);
  assign push_ovf = (top_x + EW'(1)) >= EW'(STACK_DEPTH);
  assign call_ovf = (top_x + EW'(3)) >= EW'(STACK_DEPTH);

  // Signed offsets from the frame, checked unsigned so negatives fail too
  assign fp_x   = XW'(fp_r);
  assign ld_idx = fp_x - XW'(2) - {{2{imm_r[31]}}, imm_r};
  assign ld_bad = ld_idx >= XW'(STACK_DEPTH);
  assign nt     = fp_x - XW'(2) - {{2{opnd_r[2][31]}}, opnd_r[2]};
  assign nt_bad = nt >= XW'(STACK_DEPTH);
  assign nf     = (nt == fp_x) ? opnd_r[0] : opnd_r[3];
  assign nf_bad = nf >= 32'(STACK_DEPTH);

  assign pc_p1 = pc_r + CW'(1);
  assign pc_p2 = pc_r + CW'(2);
  assign pc_p3 = pc_r + CW'(3);
  assign ra_p1 = opnd_r[1][CW-1:0] + CW'(1);

  assign mul_lo = a * b;

  always_comb begin
    case (op_r)
      smx_pkg::OP_ADD:  alu = a + b;
      smx_pkg::OP_SUB:  alu = a - b;
      smx_pkg::OP_MUL:  alu = mul_lo;
      smx_pkg::OP_DIV:  alu = quo;
      smx_pkg::OP_EQ:   alu = {31'd0, a == b};
      smx_pkg::OP_NEQ:  alu = {31'd0, a != b};
      smx_pkg::OP_LT:   alu = {31'd0, $signed(a) < $signed(b)};
      smx_pkg::OP_LTEQ: alu = {31'd0, $signed(a) <= $signed(b)};
      smx_pkg::OP_GT:   alu = {31'd0, $signed(a) > $signed(b)};
      smx_pkg::OP_GTEQ: alu = {31'd0, $signed(a) >= $signed(b)};
      default:          alu = '0;
    endcase
  end

  // Status, next architectural state and the single commit-time write
  always_comb begin
    st      = smx_pkg::ST_OK;
    top_nxt = top_r;
    fp_nxt  = fp_r;
    pc_nxt  = pc_p1;
    ex_we   = 1'b0;
    ex_addr = top_r;
    ex_data = alu;
    case (op_r)
      smx_pkg::OP_RET: begin
        if (fp_r == '0) begin
          st = smx_pkg::ST_HALT;
        end else if (fp_r < AW'(2) || nt_bad || nf_bad) begin
          st = smx_pkg::ST_UNDER;
        end
        top_nxt = nt[AW-1:0];
        fp_nxt  = nf[AW-1:0];
        pc_nxt  = ra_p1;
        ex_we   = 1'b1;
        ex_addr = nt[AW-1:0];
        ex_data = opnd_r[0];
      end
      smx_pkg::OP_POP: begin
        if (top_zero) begin
          st = smx_pkg::ST_UNDER;
        end
        top_nxt = top_r - AW'(1);
      end
      smx_pkg::OP_PUSH: begin
        if (push_ovf) begin
          st = smx_pkg::ST_OVER;
        end
        top_nxt = top_r + AW'(1);
        pc_nxt  = pc_p2;
        ex_we   = 1'b1;
        ex_addr = top_r + AW'(1);
        ex_data = imm_r;
      end
      smx_pkg::OP_PRINT: begin
      end
      smx_pkg::OP_IF_JUMP: begin
        if (top_zero) begin
          st = smx_pkg::ST_UNDER;
        end
        top_nxt = top_r - AW'(1);
        pc_nxt  = (opnd_r[0] != '0) ? imm_r[CW-1:0] : pc_p2;
      end
      smx_pkg::OP_CALL: begin
        if (call_ovf) begin
          st = smx_pkg::ST_OVER;
        end
        top_nxt = top_r + AW'(3);
        fp_nxt  = top_r + AW'(3);
        pc_nxt  = CW'(tgt_r);
        ex_we   = 1'b1;
        ex_addr = top_r + AW'(3);
        ex_data = 32'(fp_r);
      end
      smx_pkg::OP_ARG_FETCH: begin
        if (ld_bad) begin
          st = smx_pkg::ST_UNDER;
        end else if (push_ovf) begin
          st = smx_pkg::ST_OVER;
        end
        top_nxt = top_r + AW'(1);
        pc_nxt  = pc_p2;
        ex_we   = 1'b1;
        ex_addr = top_r + AW'(1);
        ex_data = opnd_r[0];
      end
      default: begin
        if (op_r >= smx_pkg::OP_ADD && op_r <= smx_pkg::OP_GTEQ) begin
          if (top_zero) begin
            st = smx_pkg::ST_UNDER;
          end else if (op_r == smx_pkg::OP_DIV && b == '0) begin
            st = smx_pkg::ST_DIV0;
          end
          top_nxt = top_r - AW'(1);
          ex_we   = 1'b1;
          ex_addr = top_r - AW'(1);
        end
      end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      smx_pkg::RD_TOP:   ram_raddr = top_r;
      smx_pkg::RD_TOPM1: ram_raddr = top_r - AW'(1);
      smx_pkg::RD_FPM1:  ram_raddr = fp_r - AW'(1);
      smx_pkg::RD_FPM2:  ram_raddr = fp_r - AW'(2);
      smx_pkg::RD_FP:    ram_raddr = fp_r;
      smx_pkg::RD_ARG:   ram_raddr = ld_idx[AW-1:0];
      default:           ram_raddr = top_r;
    endcase
  end

  always_comb begin
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.wr_call1) begin
      ram_we    = 1'b1;
      ram_waddr = top_r + AW'(1);
      ram_wdata = imm_r;
    end else if (cmd.wr_call2) begin
      ram_we    = 1'b1;
      ram_waddr = top_r + AW'(2);
      ram_wdata = 32'(pc_p3);
    end else begin
      ram_we    = cmd.commit && (st == smx_pkg::ST_OK) && ex_we;
      ram_waddr = ex_addr;
      ram_wdata = ex_data;
    end
  end

  smx_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (quo)
  );

  // Instruction and operand capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= smx_pkg::opcode_t'(in_opcode);
      imm_r <= in_immediate;
      tgt_r <= in_call_target;
    end
    if (cmd.cap_en) begin
      opnd_r[cmd.cap_idx] <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= '0;
      fp_r      <= '0;
      pc_r      <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.commit && st == smx_pkg::ST_OK) begin
        top_r <= top_nxt;
        fp_r  <= fp_nxt;
        pc_r  <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_next_pc_r     <= 16'((st == smx_pkg::ST_OK) ? pc_nxt : pc_r);
      out_status_r      <= st;
      out_print_valid_r <= (op_r == smx_pkg::OP_PRINT);
      out_print_value_r <= (op_r == smx_pkg::OP_PRINT) ? opnd_r[0] : '0;
      out_print_depth_r <= (op_r == smx_pkg::OP_PRINT) ? 10'(top_r) : '0;
    end
  end

  assign sts.op       = op_r;
  assign sts.st       = st;
  assign sts.call_ok  = !call_ovf;
  assign sts.clr_done = (clr_cnt_r == AW'(STACK_DEPTH - 1));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_status      = out_status_r;
  assign out_print_valid = out_print_valid_r;
  assign out_print_value = out_print_value_r;
  assign out_print_depth = out_print_depth_r;

endmodule

// ----- rtl/smx_ctrl.sv -----
`include "stack_machine_executor_top_defines.svh"

module smx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  smx_pkg::dp_sts_t  sts,
  output smx_pkg::ctl_cmd_t cmd
);

  smx_pkg::state_t state_r, state_nxt;
  logic is_binary, need_div;

  assign is_binary = (sts.op >= smx_pkg::OP_ADD) && (sts.op <= smx_pkg::OP_GTEQ);
  assign need_div  = (sts.op == smx_pkg::OP_DIV) && (sts.st == smx_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smx_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = smx_pkg::RD_TOP;
    case (state_r)
      smx_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = smx_pkg::S_IDLE;
        end
      end
      smx_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = smx_pkg::S_DEC;
        end
      end
      smx_pkg::S_DEC: begin
        if (sts.op == smx_pkg::OP_ARG_FETCH) begin
          cmd.rd_sel = smx_pkg::RD_ARG;
          state_nxt  = smx_pkg::S_R1;
        end else if (sts.op == smx_pkg::OP_RET || sts.op == smx_pkg::OP_PRINT ||
                     sts.op == smx_pkg::OP_IF_JUMP || is_binary) begin
          state_nxt = smx_pkg::S_R1;
        end else if (sts.op == smx_pkg::OP_CALL && sts.call_ok) begin
          state_nxt = smx_pkg::S_W1;
        end else begin
          state_nxt = smx_pkg::S_EXEC;
        end
      end
      smx_pkg::S_R1: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd0;
        if (is_binary) begin
          cmd.rd_sel = smx_pkg::RD_TOPM1;
          state_nxt  = smx_pkg::S_R2;
        end else if (sts.op == smx_pkg::OP_RET) begin
          cmd.rd_sel = smx_pkg::RD_FPM1;
          state_nxt  = smx_pkg::S_R2;
        end else begin
          state_nxt = smx_pkg::S_EXEC;
        end
      end
      smx_pkg::S_R2: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd1;
        if (sts.op == smx_pkg::OP_RET) begin
          cmd.rd_sel = smx_pkg::RD_FPM2;
          state_nxt  = smx_pkg::S_R3;
        end else begin
          state_nxt = smx_pkg::S_EXEC;
        end
      end
      smx_pkg::S_R3: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd2;
        cmd.rd_sel  = smx_pkg::RD_FP;
        state_nxt   = smx_pkg::S_R4;
      end
      smx_pkg::S_R4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd3;
        state_nxt   = smx_pkg::S_EXEC;
      end
      smx_pkg::S_W1: begin
        cmd.wr_call1 = 1'b1;
        state_nxt    = smx_pkg::S_W2;
      end
      smx_pkg::S_W2: begin
        cmd.wr_call2 = 1'b1;
        state_nxt    = smx_pkg::S_EXEC;
      end
      smx_pkg::S_EXEC: begin
        if (need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = smx_pkg::S_DIV;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = smx_pkg::S_IDLE;
        end
      end
      smx_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = smx_pkg::S_DWB;
        end
      end
      smx_pkg::S_DWB: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = smx_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = smx_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != smx_pkg::S_IDLE);

  `SMX_ASSERT(a_commit_room, clk, rst_n, cmd.commit |-> sts.out_free, "commit with output full")
  `SMX_ASSERT(a_call_seq, clk, rst_n, cmd.wr_call1 |=> cmd.wr_call2, "call writes out of order")
  `SMX_ASSERT(a_div_op, clk, rst_n, cmd.div_start |-> sts.op == smx_pkg::OP_DIV, "bad div start")
  `SMX_ASSERT_ALWAYS(a_clr_no_accept, clk, !(cmd.clr_wr && cmd.accept), "accept during clear")

endmodule

// ----- rtl/stack_machine_executor_top.sv -----
// Stack machine executor: executes one decoded instruction per input transaction and returns
// one result transaction holding the next fetch address, a status code and, for print, the
// printed top-of-stack value and depth. After reset the block runs a clearing pass over the
// stack memory, one entry per cycle, and holds in_stall high until it ends. After accept and
// decode, an instruction goes straight to commit when it needs no stack read (push, pop,
// unknown codes, a call that overflows); print, if_jump and argument fetch first read one
// operand, binary operations two and return four, one read state each, as the stack memory
// has a single read port, and a call first makes its two frame writes. A divide also waits
// for the bit-serial divider before commit. The result shows on out_valid the cycle after
// commit, and commit holds while the output register still carries an untaken result. A new
// transaction is taken in the cycle after commit, while the previous result may still wait
// in the output register. A nonzero status leaves all state untouched and returns the
// current address.
module stack_machine_executor_top #(
  parameter int STACK_DEPTH    = 1024,
  parameter int CODE_ADDR_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // instruction channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_opcode,
  input  logic signed [31:0] in_immediate,
  input  logic [15:0]        in_call_target,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_next_pc,
  output logic [2:0]         out_status,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic [9:0]         out_print_depth
);

  smx_pkg::ctl_cmd_t cmd;
  smx_pkg::dp_sts_t  sts;

  // Sequencer: decides reads, call writes, divide and commit
  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stack memory, pointers, ALU, divider and output register
  smx_dp #(
    .STACK_DEPTH    (STACK_DEPTH),
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_immediate    (in_immediate),
    .in_call_target  (in_call_target),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_status      (out_status),
    .out_print_valid (out_print_valid),
    .out_print_value (out_print_value),
    .out_print_depth (out_print_depth)
  );

endmodule
